@@ rtl/core/dro_pkg.sv @@
// ----------------------------------------------------------------------------
// dro_pkg: shared definitions for the date range overlap block
// Widths, calendar tables, reciprocal constants and the control structs
// passed between the top level and the day-count engine.
// ----------------------------------------------------------------------------
package dro_pkg;

  // Largest year accepted; larger years are clamped to it.
  localparam int YEAR_MAX = 9999;

  // Field widths of one transaction.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OUT_W   = 22;
  localparam int OUT_MAX = (1 << OUT_W) - 1;

  // A clamped year never exceeds what the year field can carry.
  localparam int YEAR_FIELD_MAX = (1 << YEAR_W) - 1;
  localparam int YEAR_TOP = (YEAR_MAX < YEAR_FIELD_MAX) ? YEAR_MAX : YEAR_FIELD_MAX;

  // Day serial width and the width of the overlap count before saturation.
  localparam int SERIAL_W = $clog2(YEAR_TOP * 366 + 1);
  localparam int CNT_W    = ((SERIAL_W > OUT_W) ? SERIAL_W : OUT_W) + 1;

  // Shared multiply-add unit: a * b + c.
  localparam int MAC_A_W = YEAR_W;
  localparam int MAC_B_W = 20;
  localparam int MAC_P_W = MAC_A_W + MAC_B_W;

  // y / 100 is taken as (y * RECIP_100) >> RECIP_SHIFT, exact for any 14-bit year.
  localparam int RECIP_SHIFT = 26;
  localparam logic [MAC_B_W-1:0] RECIP_100 = MAC_B_W'(((1 << RECIP_SHIFT) / 100) + 1);
  localparam logic [MAC_B_W-1:0] HUNDRED   = MAC_B_W'(100);
  localparam logic [MAC_B_W-1:0] YEAR_DAYS = MAC_B_W'(365);

  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = DAY_W'(29);
  localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_LAST   = MONTH_W'(12);

  // Date slots within one transaction.
  localparam int NUM_DATES = 4;
  localparam logic [1:0] SLOT_A_START = 2'd0;
  localparam logic [1:0] SLOT_A_END   = 2'd1;
  localparam logic [1:0] SLOT_B_START = 2'd2;
  localparam logic [1:0] SLOT_B_END   = 2'd3;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic start;  // begin a new count on the captured dates
    logic ack;    // result has been taken by the output stage
  } calc_ctl_t;

  typedef struct packed {
    logic done;   // result is ready and held until acknowledged
  } calc_stat_t;

  // Length of a month in a common year; index 0 is January.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mi);
    logic [DAY_W-1:0] len;
    case (mi)
      4'd1:                  len = DAY_W'(28);
      4'd3, 4'd5, 4'd8, 4'd10: len = DAY_W'(30);
      default:               len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // Days before the first of a month in a common year; index 0 is January.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mi);
    logic [8:0] dd;
    case (mi)
      4'd0:    dd = 9'd0;
      4'd1:    dd = 9'd31;
      4'd2:    dd = 9'd59;
      4'd3:    dd = 9'd90;
      4'd4:    dd = 9'd120;
      4'd5:    dd = 9'd151;
      4'd6:    dd = 9'd181;
      4'd7:    dd = 9'd212;
      4'd8:    dd = 9'd243;
      4'd9:    dd = 9'd273;
      4'd10:   dd = 9'd304;
      default: dd = 9'd334;
    endcase
    return dd;
  endfunction

endpackage

@@ rtl/core/dro_mac.sv @@
// ----------------------------------------------------------------------------
// dro_mac: shared multiply-add unit
// Computes a * b + c with a registered result; every product of the
// day-count engine goes through this one unit.
// ----------------------------------------------------------------------------
module dro_mac (
  input  logic                         clk,
  input  logic [dro_pkg::MAC_A_W-1:0]  a,
  input  logic [dro_pkg::MAC_B_W-1:0]  b,
  input  logic [dro_pkg::SERIAL_W-1:0] c,
  output logic [dro_pkg::MAC_P_W-1:0]  prod
);

  logic [dro_pkg::MAC_P_W-1:0] mul;

  // Unsigned product at full width.
  assign mul = dro_pkg::MAC_P_W'(a) * dro_pkg::MAC_P_W'(b);

  // Result register; read in the cycle after the operands are driven.
  always_ff @(posedge clk) begin
    prod <= mul + dro_pkg::MAC_P_W'(c);
  end

endmodule

@@ rtl/core/dro_calc.sv @@
// ----------------------------------------------------------------------------
// dro_calc: day-count engine
// Turns the four captured dates into day serials one after another on the
// shared multiply-add unit, then forms the inclusive overlap count.
// ----------------------------------------------------------------------------
module dro_calc (
  input  logic                      clk,
  input  logic                      rst,
  input  dro_pkg::date_t            dates [dro_pkg::NUM_DATES],
  input  dro_pkg::calc_ctl_t        ctl,
  output dro_pkg::calc_stat_t       stat,
  output logic [dro_pkg::OUT_W-1:0] result
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_QUOT   = 4'd1;
  localparam logic [3:0] ST_HUND   = 4'd2;
  localparam logic [3:0] ST_LEAP   = 4'd3;
  localparam logic [3:0] ST_SUM    = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_STORE  = 4'd6;
  localparam logic [3:0] ST_MINMAX = 4'd7;
  localparam logic [3:0] ST_DIFF   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] idx;

  logic [dro_pkg::YEAR_W-1:0]   q_reg;
  logic [dro_pkg::YEAR_W-1:0]   p100_reg;
  logic                         leap_reg;
  logic [dro_pkg::SERIAL_W-1:0] sum_reg;
  logic [dro_pkg::SERIAL_W-1:0] serial [dro_pkg::NUM_DATES];
  logic [dro_pkg::SERIAL_W-1:0] lo;
  logic [dro_pkg::SERIAL_W-1:0] hi;

  dro_pkg::date_t               cur;
  logic [dro_pkg::YEAR_W-1:0]   yc;
  logic [dro_pkg::YEAR_W-1:0]   p;
  logic [dro_pkg::MONTH_W-1:0]  mc;
  logic [dro_pkg::MONTH_W-1:0]  mi;
  logic [dro_pkg::DAY_W-1:0]    ml;
  logic [dro_pkg::DAY_W-1:0]    dc;
  logic                         hund_hit;
  logic [dro_pkg::YEAR_W-1:0]   quot;
  logic [dro_pkg::SERIAL_W-1:0] sum_next;
  logic [dro_pkg::CNT_W-1:0]    cnt;

  logic [dro_pkg::MAC_A_W-1:0]  mac_a;
  logic [dro_pkg::MAC_B_W-1:0]  mac_b;
  logic [dro_pkg::SERIAL_W-1:0] mac_c;
  logic [dro_pkg::MAC_P_W-1:0]  mac_out;

  // Clamp the date being worked on into the calendar.
  always_comb begin
    cur = dates[idx];
    if (cur.year == '0) begin
      yc = dro_pkg::YEAR_W'(1);
    end else if (32'(cur.year) > dro_pkg::YEAR_MAX) begin
      yc = dro_pkg::YEAR_W'(dro_pkg::YEAR_MAX);
    end else begin
      yc = cur.year;
    end
    if (cur.month == '0) begin
      mc = dro_pkg::MONTH_W'(1);
    end else if (cur.month > dro_pkg::MONTH_LAST) begin
      mc = dro_pkg::MONTH_LAST;
    end else begin
      mc = cur.month;
    end
    mi = mc - dro_pkg::MONTH_W'(1);
    if (mc == dro_pkg::MONTH_FEB && leap_reg) begin
      ml = dro_pkg::FEB_LEAP_LEN;
    end else begin
      ml = dro_pkg::month_len(mi);
    end
    if (cur.day == '0) begin
      dc = dro_pkg::DAY_W'(1);
    end else if (cur.day > ml) begin
      dc = ml;
    end else begin
      dc = cur.day;
    end
    p = yc - dro_pkg::YEAR_W'(1);
  end

  // Quotient by 100 and the century test from the shared unit's results.
  assign quot     = dro_pkg::YEAR_W'(mac_out >> dro_pkg::RECIP_SHIFT);
  assign hund_hit = (mac_out == dro_pkg::MAC_P_W'(yc));

  // Everything of the serial except the 365-day years term.
  assign sum_next = dro_pkg::SERIAL_W'(dc)
                  + dro_pkg::SERIAL_W'(dro_pkg::days_before(mi))
                  + dro_pkg::SERIAL_W'(leap_reg && (mc > dro_pkg::MONTH_FEB))
                  + dro_pkg::SERIAL_W'(p >> 2)
                  - dro_pkg::SERIAL_W'(p100_reg)
                  + dro_pkg::SERIAL_W'(p100_reg >> 2);

  // Operand select for the shared unit.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    case (state)
      ST_QUOT: begin
        mac_a = yc;
        mac_b = dro_pkg::RECIP_100;
      end
      ST_HUND: begin
        mac_a = quot;
        mac_b = dro_pkg::HUNDRED;
      end
      ST_MUL: begin
        mac_a = p;
        mac_b = dro_pkg::YEAR_DAYS;
        mac_c = sum_reg;
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  dro_mac u_mac (
    .clk  (clk),
    .a    (mac_a),
    .b    (mac_b),
    .c    (mac_c),
    .prod (mac_out)
  );

  // Sequencer: six steps per date, then the overlap.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (ctl.start) state_next = ST_QUOT;
      ST_QUOT:   state_next = ST_HUND;
      ST_HUND:   state_next = ST_LEAP;
      ST_LEAP:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_MUL;
      ST_MUL:    state_next = ST_STORE;
      ST_STORE:  state_next = (idx == dro_pkg::SLOT_B_END) ? ST_MINMAX : ST_QUOT;
      ST_MINMAX: state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_DONE;
      ST_DONE:   if (ctl.ack) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= dro_pkg::SLOT_A_START;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        idx <= dro_pkg::SLOT_A_START;
      end else if (state == ST_STORE) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Inclusive count from the latest start to the earliest end.
  assign cnt = dro_pkg::CNT_W'(hi) - dro_pkg::CNT_W'(lo) + dro_pkg::CNT_W'(1);

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_HUND: begin
        q_reg <= quot;
      end
      ST_LEAP: begin
        leap_reg <= ((yc[1:0] == 2'd0) && !hund_hit) || (hund_hit && (q_reg[1:0] == 2'd0));
        p100_reg <= hund_hit ? (q_reg - dro_pkg::YEAR_W'(1)) : q_reg;
      end
      ST_SUM: begin
        sum_reg <= sum_next;
      end
      ST_STORE: begin
        serial[idx] <= mac_out[dro_pkg::SERIAL_W-1:0];
      end
      ST_MINMAX: begin
        lo <= (serial[dro_pkg::SLOT_A_START] > serial[dro_pkg::SLOT_B_START]) ?
              serial[dro_pkg::SLOT_A_START] : serial[dro_pkg::SLOT_B_START];
        hi <= (serial[dro_pkg::SLOT_A_END] < serial[dro_pkg::SLOT_B_END]) ?
              serial[dro_pkg::SLOT_A_END] : serial[dro_pkg::SLOT_B_END];
      end
      ST_DIFF: begin
        if (hi < lo) begin
          result <= '0;
        end else if (cnt > dro_pkg::CNT_W'(dro_pkg::OUT_MAX)) begin
          result <= dro_pkg::OUT_W'(dro_pkg::OUT_MAX);
        end else begin
          result <= cnt[dro_pkg::OUT_W-1:0];
        end
      end
      default: begin
        q_reg <= q_reg;
      end
    endcase
  end

  assign stat.done = (state == ST_DONE);

`ifndef ASSERT_OFF
  // The reciprocal quotient must be exact: 100q <= y < 100q + 100.
  a_quot_exact: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEAP) |-> (mac_out <= dro_pkg::MAC_P_W'(yc)) &&
      (mac_out + dro_pkg::MAC_P_W'(dro_pkg::HUNDRED) > dro_pkg::MAC_P_W'(yc)))
    else $error("dro_calc: year quotient by 100 is off");

  // A finished day serial fits its register.
  a_serial_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |-> (mac_out >> dro_pkg::SERIAL_W) == '0)
    else $error("dro_calc: day serial overflows");

  // An acknowledged result returns the engine to idle.
  a_ack_idle: assert property (@(posedge clk) disable iff (rst)
    (stat.done && ctl.ack) |=> (state == ST_IDLE))
    else $error("dro_calc: engine did not release after ack");
`endif

endmodule

@@ rtl/core/date_range_overlap_days.sv @@
// ----------------------------------------------------------------------------
// date_range_overlap_days: days shared by two Gregorian date periods
// Captures two periods, converts their four dates to day serials and
// returns the number of days common to both, both ends counted.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid / in_ready    a_*, b_* start and end year, month, day
//  output   out_valid / out_ready  overlap_days
//
// A transaction runs from input accept to out_valid through start, the four
// dates in turn on the shared multiply-add unit, then min/max, difference
// and handoff. Sharing the one multiply-add unit serializes the dates.
// Reset is synchronous and clears all control state; no stored tables.
// in_ready is low while a transaction is in the engine. A finished result
// waits in the output register, so one new transaction may be accepted
// while out_ready is held low; a later result then waits in the engine.
module date_range_overlap_days (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dro_pkg::YEAR_W-1:0]  a_start_year,
  input  logic [dro_pkg::MONTH_W-1:0] a_start_month,
  input  logic [dro_pkg::DAY_W-1:0]   a_start_day,
  input  logic [dro_pkg::YEAR_W-1:0]  a_end_year,
  input  logic [dro_pkg::MONTH_W-1:0] a_end_month,
  input  logic [dro_pkg::DAY_W-1:0]   a_end_day,
  input  logic [dro_pkg::YEAR_W-1:0]  b_start_year,
  input  logic [dro_pkg::MONTH_W-1:0] b_start_month,
  input  logic [dro_pkg::DAY_W-1:0]   b_start_day,
  input  logic [dro_pkg::YEAR_W-1:0]  b_end_year,
  input  logic [dro_pkg::MONTH_W-1:0] b_end_month,
  input  logic [dro_pkg::DAY_W-1:0]   b_end_day,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dro_pkg::OUT_W-1:0]   overlap_days
);

  logic                      busy;
  logic                      start;
  logic                      in_accept;
  logic                      handoff;
  dro_pkg::date_t            dates [dro_pkg::NUM_DATES];
  dro_pkg::calc_ctl_t        calc_ctl;
  dro_pkg::calc_stat_t       calc_stat;
  logic [dro_pkg::OUT_W-1:0] calc_result;

  assign in_ready  = !busy;
  assign in_accept = in_valid && in_ready;

  // Move a finished result into the output register when it is free.
  assign handoff = calc_stat.done && (!out_valid || out_ready);

  assign calc_ctl.start = start;
  assign calc_ctl.ack   = handoff;

  // Transaction tracking and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= in_accept;
      if (in_accept) begin
        busy <= 1'b1;
      end else if (handoff) begin
        busy <= 1'b0;
      end
      if (handoff) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input capture and output data.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      dates[dro_pkg::SLOT_A_START] <= '{a_start_year, a_start_month, a_start_day};
      dates[dro_pkg::SLOT_A_END]   <= '{a_end_year, a_end_month, a_end_day};
      dates[dro_pkg::SLOT_B_START] <= '{b_start_year, b_start_month, b_start_day};
      dates[dro_pkg::SLOT_B_END]   <= '{b_end_year, b_end_month, b_end_day};
    end
    if (handoff) begin
      overlap_days <= calc_result;
    end
  end

  dro_calc u_calc (
    .clk    (clk),
    .rst    (rst),
    .dates  (dates),
    .ctl    (calc_ctl),
    .stat   (calc_stat),
    .result (calc_result)
  );

`ifndef ASSERT_OFF
  // An accepted transaction keeps the input closed on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("date_range_overlap_days: input reopened after accept");

  // The engine reports a result only while a transaction is open.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    calc_stat.done |-> busy)
    else $error("date_range_overlap_days: result with no open transaction");

  // A handoff always presents the result on the next cycle.
  a_handoff_valid: assert property (@(posedge clk) disable iff (rst)
    handoff |=> out_valid && !busy)
    else $error("date_range_overlap_days: handoff lost");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for date_range_overlap_days
// Sends pairs of date periods through the input handshake and predicts the
// count of shared calendar days for each one. Every result is compared with
// the oldest pending prediction. A directed set covers clamped fields, leap
// years, reversed, touching and disjoint periods. Random traffic then runs
// under three idle mixes, with a long receiver hold-off to back up the block.
// ----------------------------------------------------------------------------
module tb;

  // One input transaction: the four dates of two periods.
  typedef struct packed {
    dro_pkg::date_t a_start;
    dro_pkg::date_t a_end;
    dro_pkg::date_t b_start;
    dro_pkg::date_t b_end;
  } period_pair_t;

  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int LONG_HOLD        = 200;
  localparam int RANDOM_PER_PHASE = 330;
  localparam int REPORT_MAX       = 10;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [dro_pkg::OUT_W-1:0] overlap_days;
  period_pair_t              cur_pair  = '0;

  period_pair_t              pending_q[$];
  logic [dro_pkg::OUT_W-1:0] overlap_q[$];
  int                        send_idle_pct = 29;
  int                        recv_idle_pct = 61;
  bit                        recv_hold_go  = 1'b0;
  int                        mismatches    = 0;
  int                        hold_left     = 0;
  bit                        hold_used     = 1'b0;
  int                        quiet_cycles  = 0;
  logic [dro_pkg::OUT_W-1:0] want_days;

  date_range_overlap_days u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .a_start_year  (cur_pair.a_start.year),
    .a_start_month (cur_pair.a_start.month),
    .a_start_day   (cur_pair.a_start.day),
    .a_end_year    (cur_pair.a_end.year),
    .a_end_month   (cur_pair.a_end.month),
    .a_end_day     (cur_pair.a_end.day),
    .b_start_year  (cur_pair.b_start.year),
    .b_start_month (cur_pair.b_start.month),
    .b_start_day   (cur_pair.b_start.day),
    .b_end_year    (cur_pair.b_end.year),
    .b_end_month   (cur_pair.b_end.month),
    .b_end_day     (cur_pair.b_end.day),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .overlap_days  (overlap_days)
  );

  always #5 clk = ~clk;

  // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    case (m)
      2:           return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Day number of a date, day 1 being January 1 of year 1. Out-of-range
  // fields are pulled to the nearest legal value first.
  function automatic int unsigned day_number(dro_pkg::date_t dt);
    int unsigned y, m, d, p, n;
    y = dt.year;
    m = dt.month;
    d = dt.day;
    if (y < 1) y = 1;
    if (y > dro_pkg::YEAR_MAX) y = dro_pkg::YEAR_MAX;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > month_days(m, y)) d = month_days(m, y);
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400 + d;
    for (int unsigned k = 1; k < m; k++) n += month_days(k, y);
    return n;
  endfunction

  // Days common to both periods, both ends counted, saturated to the port.
  function automatic logic [dro_pkg::OUT_W-1:0] shared_days(period_pair_t pp);
    int unsigned as, ae, bs, be, lo, hi, n;
    as = day_number(pp.a_start);
    ae = day_number(pp.a_end);
    bs = day_number(pp.b_start);
    be = day_number(pp.b_end);
    lo = (as > bs) ? as : bs;
    hi = (ae < be) ? ae : be;
    n  = 0;
    if (hi >= lo) begin
      n = hi - lo + 1;
      if (n > dro_pkg::OUT_MAX) n = dro_pkg::OUT_MAX;
    end
    return n[dro_pkg::OUT_W-1:0];
  endfunction

  function automatic dro_pkg::date_t make_date(int y, int m, int d);
    dro_pkg::date_t dt;
    dt.year  = y[dro_pkg::YEAR_W-1:0];
    dt.month = m[dro_pkg::MONTH_W-1:0];
    dt.day   = d[dro_pkg::DAY_W-1:0];
    return dt;
  endfunction

  function automatic period_pair_t periods(
    int ay0, int am0, int ad0, int ay1, int am1, int ad1,
    int by0, int bm0, int bd0, int by1, int bm1, int bd1);
    period_pair_t pp;
    pp.a_start = make_date(ay0, am0, ad0);
    pp.a_end   = make_date(ay1, am1, ad1);
    pp.b_start = make_date(by0, bm0, bd0);
    pp.b_end   = make_date(by1, bm1, bd1);
    return pp;
  endfunction

  function automatic dro_pkg::date_t date_in_year(int unsigned y);
    dro_pkg::date_t dt;
    dt.year  = y[dro_pkg::YEAR_W-1:0];
    dt.month = dro_pkg::MONTH_W'($urandom_range(12, 1));
    dt.day   = dro_pkg::DAY_W'($urandom_range(31, 1));
    return dt;
  endfunction

  // Mostly periods a few years apart so that they often meet; some wide
  // spans; the rest raw field noise that exercises the clamping.
  function automatic period_pair_t random_periods();
    period_pair_t pp;
    logic [95:0] raw;
    int unsigned sel, base, ys;
    sel = $urandom_range(99);
    if (sel < 70) begin
      case ($urandom_range(9))
        0:       base = $urandom_range(3, 1);
        1:       base = $urandom_range(dro_pkg::YEAR_MAX, dro_pkg::YEAR_MAX - 3);
        default: base = $urandom_range(dro_pkg::YEAR_MAX, 1);
      endcase
      ys         = base + $urandom_range(1);
      pp.a_start = date_in_year(ys);
      pp.a_end   = date_in_year(ys + $urandom_range(2));
      ys         = base + $urandom_range(2);
      pp.b_start = date_in_year(ys);
      pp.b_end   = date_in_year(ys + $urandom_range(2));
    end else if (sel < 82) begin
      ys         = $urandom_range(dro_pkg::YEAR_MAX, 1);
      pp.a_start = date_in_year(ys);
      pp.a_end   = date_in_year($urandom_range(dro_pkg::YEAR_MAX, ys));
      ys         = $urandom_range(dro_pkg::YEAR_MAX, 1);
      pp.b_start = date_in_year(ys);
      pp.b_end   = date_in_year($urandom_range(dro_pkg::YEAR_MAX, ys));
    end else begin
      raw = {$urandom, $urandom, $urandom};
      pp  = raw[$bits(period_pair_t)-1:0];
    end
    return pp;
  endfunction

  task automatic report_fail(string why, logic [dro_pkg::OUT_W-1:0] want,
                             logic [dro_pkg::OUT_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: expected %0d, got %0d", $time, why, want, got);
  endtask

  // Returns once every queued transaction has been sent and answered.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || overlap_q.size() != 0) @(negedge clk);
  endtask

  // Input driver: presents the next queued transaction once the last one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) overlap_q.push_back(shared_days(cur_pair));
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_pair <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: checks each result and throttles out_ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (overlap_q.size() == 0) begin
        report_fail("result with no transaction pending", '0, overlap_days);
      end else begin
        want_days = overlap_q.pop_front();
        if (overlap_days !== want_days) report_fail("overlap_days mismatch", want_days, overlap_days);
      end
    end
    if (recv_hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single leap day in both periods.
    pending_q.push_back(periods(2024, 2, 29, 2024, 2, 29, 2024, 2, 29, 2024, 2, 29));
    // Whole calendar in both periods.
    pending_q.push_back(periods(1, 1, 1, 9999, 12, 31, 1, 1, 1, 9999, 12, 31));
    // All fields zero, then all fields at their top bit pattern.
    pending_q.push_back('0);
    pending_q.push_back('1);
    // Disjoint, touching, and each period reversed.
    pending_q.push_back(periods(2020, 1, 1, 2020, 6, 30, 2020, 7, 1, 2020, 12, 31));
    pending_q.push_back(periods(2020, 1, 1, 2020, 7, 1, 2020, 7, 1, 2020, 12, 31));
    pending_q.push_back(periods(2021, 5, 10, 2021, 5, 1, 1, 1, 1, 9999, 12, 31));
    pending_q.push_back(periods(1, 1, 1, 9999, 12, 31, 2021, 5, 10, 2021, 5, 1));
    // Nested across a year end, and a partial overlap across a century.
    pending_q.push_back(periods(1999, 12, 31, 2001, 1, 1, 2000, 2, 1, 2000, 3, 31));
    pending_q.push_back(periods(1899, 6, 1, 1900, 3, 1, 1900, 2, 1, 1901, 1, 1));
    // February days past month end in century and 400-year cases, and a leap day.
    pending_q.push_back(periods(1900, 2, 31, 1900, 3, 1, 1900, 2, 1, 1900, 2, 31));
    pending_q.push_back(periods(2100, 2, 30, 2100, 3, 2, 2100, 1, 1, 2100, 12, 31));
    pending_q.push_back(periods(2000, 2, 30, 2000, 3, 1, 2000, 2, 28, 2000, 3, 1));
    pending_q.push_back(periods(2004, 2, 29, 2004, 3, 1, 2003, 12, 1, 2004, 3, 1));
    // Day 31 in a 30-day month, month and day zero, months above 12.
    pending_q.push_back(periods(2023, 4, 31, 2023, 5, 1, 2023, 4, 1, 2023, 4, 30));
    pending_q.push_back(periods(2022, 0, 0, 2022, 13, 5, 2022, 1, 1, 2022, 15, 31));
    // Year zero and years past the maximum.
    pending_q.push_back(periods(0, 1, 1, 1, 1, 10, 1, 1, 5, 2, 1, 1));
    pending_q.push_back(periods(9998, 12, 1, 10000, 6, 1, 9999, 12, 31, 16383, 12, 31));
    pending_q.push_back(periods(9999, 12, 31, 9999, 12, 31, 9999, 1, 1, 9999, 12, 31));
    wait_drained();

    // Random traffic under three idle mixes; the sender pauses between them.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 29; recv_idle_pct = 61; end
        1:       begin send_idle_pct = 61; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) pending_q.push_back(random_periods());
      // In the last phase the receiver holds off while the sender keeps going.
      if (phase == 2) recv_hold_go = 1'b1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
